// ----- hdl/tvdl_pkg.sv -----
package tvdl_pkg;

    localparam int COORD_W = 20;
    localparam int TOL_W   = 8;
    localparam int LANES   = 3;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd16;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vert_t;

    typedef struct packed {
        logic start;
        logic valid;
    } lane_ctl_t;

    typedef struct packed {
        logic   found;
        point_t hit;
        vert_t  vert;
    } lane_res_t;

endpackage

// ----- hdl/tvdl_in_if.sv -----
interface tvdl_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic signed [tvdl_pkg::COORD_W-1:0] load_x;
    logic signed [tvdl_pkg::COORD_W-1:0] load_y;
    logic signed [tvdl_pkg::COORD_W-1:0] load_z;
    logic signed [tvdl_pkg::COORD_W-1:0] vert1_x;
    logic signed [tvdl_pkg::COORD_W-1:0] vert1_y;
    logic signed [tvdl_pkg::COORD_W-1:0] vert2_x;
    logic signed [tvdl_pkg::COORD_W-1:0] vert2_y;
    logic signed [tvdl_pkg::COORD_W-1:0] vert3_x;
    logic signed [tvdl_pkg::COORD_W-1:0] vert3_y;

    modport source
    (
        output valid, opcode, load_x, load_y, load_z,
        output vert1_x, vert1_y, vert2_x, vert2_y, vert3_x, vert3_y,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, load_x, load_y, load_z,
        input  vert1_x, vert1_y, vert2_x, vert2_y, vert3_x, vert3_y,
        output ready
    );
endinterface

// ----- hdl/tvdl_out_if.sv -----
interface tvdl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tvdl_pkg::COORD_W-1:0] out1_x;
    logic signed [tvdl_pkg::COORD_W-1:0] out1_y;
    logic signed [tvdl_pkg::COORD_W-1:0] out1_z;
    logic signed [tvdl_pkg::COORD_W-1:0] out2_x;
    logic signed [tvdl_pkg::COORD_W-1:0] out2_y;
    logic signed [tvdl_pkg::COORD_W-1:0] out2_z;
    logic signed [tvdl_pkg::COORD_W-1:0] out3_x;
    logic signed [tvdl_pkg::COORD_W-1:0] out3_y;
    logic signed [tvdl_pkg::COORD_W-1:0] out3_z;

    modport source
    (
        output valid, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z,
        output out3_x, out3_y, out3_z,
        input  ready
    );

    modport sink
    (
        input  valid, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z,
        input  out3_x, out3_y, out3_z,
        output ready
    );
endinterface

// ----- hdl/tvdl_point_mem.sv -----
module tvdl_point_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  tvdl_pkg::point_t  wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output tvdl_pkg::point_t  rdata
);

    tvdl_pkg::point_t mem [DEPTH];
    tvdl_pkg::point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tvdl_lane.sv -----
module tvdl_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tvdl_pkg::lane_ctl_t           ctl,
    input  tvdl_pkg::vert_t               vert,
    input  tvdl_pkg::point_t              entry,
    input  logic [tvdl_pkg::TOL_W-1:0]    tol,
    output tvdl_pkg::lane_res_t           res
);

    localparam int DW = tvdl_pkg::COORD_W + 1;

    logic             found_reg;
    logic             found_next;
    tvdl_pkg::point_t hit_reg;
    tvdl_pkg::point_t hit_next;
    tvdl_pkg::vert_t  vert_reg;
    tvdl_pkg::vert_t  vert_next;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] tol_s;
    logic                 hit;

    always_comb
    begin
        tol_s = signed'({{(DW - tvdl_pkg::TOL_W){1'b0}}, tol});
        dx    = signed'({vert_reg.x[tvdl_pkg::COORD_W-1], vert_reg.x})
              - signed'({entry.x[tvdl_pkg::COORD_W-1], entry.x});
        dy    = signed'({vert_reg.y[tvdl_pkg::COORD_W-1], vert_reg.y})
              - signed'({entry.y[tvdl_pkg::COORD_W-1], entry.y});
        hit   = (dx <= tol_s) && (dx >= -tol_s) && (dy <= tol_s) && (dy >= -tol_s);
    end

    always_comb
    begin
        found_next = found_reg;
        hit_next   = hit_reg;
        vert_next  = vert_reg;
        if (ctl.start)
        begin
            found_next = 1'b0;
            vert_next  = vert;
        end
        else if (ctl.valid && !found_reg && hit)
        begin
            // first hit in load order wins
            found_next = 1'b1;
            hit_next   = entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        vert_reg <= vert_next;
    end

    assign res.found = found_reg;
    assign res.hit   = hit_reg;
    assign res.vert  = vert_reg;

endmodule

// ----- hdl/tvdl_merge.sv -----
module tvdl_merge (
    input  tvdl_pkg::lane_res_t res [tvdl_pkg::LANES],
    output tvdl_pkg::point_t    pts [tvdl_pkg::LANES]
);

    always_comb
    begin
        for (int i = 0; i < tvdl_pkg::LANES; i++)
        begin
            // a hit at the origin counts as no hit
            if (res[i].found && (res[i].hit.x != '0 || res[i].hit.y != '0))
            begin
                pts[i] = res[i].hit;
            end
            else
            begin
                pts[i].x = res[i].vert.x;
                pts[i].y = res[i].vert.y;
                pts[i].z = '0;
            end
        end
    end

endmodule

// ----- hdl/triangle_vertex_depth_lookup_top.sv -----
// Point table with triangle lookup. A clear or append transaction gives no
// result and leaves the block ready. A query scans the table (an empty one
// is not scanned) and then waits while an earlier result still sits in the
// output register: the table memory is read one entry per cycle through
// its single read port, and three comparison lanes, one per vertex, check
// each entry at once; the result then sits in an output register while
// clear and append transactions are taken again. The user must write
// match_tolerance through cfg_we/cfg_wdata only while the block is idle;
// the block does not enforce this. Appends beyond MAX_POINTS are dropped.
module triangle_vertex_depth_lookup_top #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tvdl_in_if.sink                      in_ch,
    tvdl_out_if.source                   out_ch,
    input  logic                         cfg_we,
    input  logic [tvdl_pkg::TOL_W-1:0]   cfg_wdata
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TAIL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [CW-1:0]               addr_reg;
    logic [CW-1:0]               addr_next;
    logic                        rd_valid_reg;
    logic [tvdl_pkg::TOL_W-1:0]  tol_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    tvdl_pkg::point_t            out_reg [tvdl_pkg::LANES];

    logic                        accept;
    logic                        mem_we;
    logic                        mem_re;
    logic                        out_load;
    tvdl_pkg::point_t            wr_point;
    tvdl_pkg::point_t            rd_point;
    tvdl_pkg::vert_t             verts    [tvdl_pkg::LANES];
    tvdl_pkg::lane_res_t         lane_res [tvdl_pkg::LANES];
    tvdl_pkg::point_t            merged   [tvdl_pkg::LANES];
    tvdl_pkg::lane_ctl_t         lane_ctl;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    assign wr_point.x = in_ch.load_x;
    assign wr_point.y = in_ch.load_y;
    assign wr_point.z = in_ch.load_z;

    assign verts[0].x = in_ch.vert1_x;
    assign verts[0].y = in_ch.vert1_y;
    assign verts[1].x = in_ch.vert2_x;
    assign verts[1].y = in_ch.vert2_y;
    assign verts[2].x = in_ch.vert3_x;
    assign verts[2].y = in_ch.vert3_y;

    assign mem_we = accept && (in_ch.opcode == tvdl_pkg::OP_APPEND) && (count_reg != FULL);
    assign mem_re = (state_reg == S_SCAN);

    assign lane_ctl.start = accept && (in_ch.opcode == tvdl_pkg::OP_QUERY);
    assign lane_ctl.valid = rd_valid_reg;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.opcode)
                        tvdl_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        tvdl_pkg::OP_APPEND:
                        begin
                            if (count_reg != FULL)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        tvdl_pkg::OP_QUERY:
                        begin
                            addr_next  = '0;
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (addr_reg == count_reg - 1'b1)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            tol_reg       <= tvdl_pkg::TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= mem_re;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= merged;
        end
    end

    tvdl_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_point),
        .re    (mem_re),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rd_point)
    );

    for (genvar g = 0; g < tvdl_pkg::LANES; g++)
    begin : g_lane
        tvdl_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .vert  (verts[g]),
            .entry (rd_point),
            .tol   (tol_reg),
            .res   (lane_res[g])
        );
    end

    tvdl_merge u_merge (
        .res (lane_res),
        .pts (merged)
    );

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.out1_x = out_reg[0].x;
    assign out_ch.out1_y = out_reg[0].y;
    assign out_ch.out1_z = out_reg[0].z;
    assign out_ch.out2_x = out_reg[1].x;
    assign out_ch.out2_y = out_reg[1].y;
    assign out_ch.out2_z = out_reg[1].z;
    assign out_ch.out3_x = out_reg[2].x;
    assign out_ch.out3_y = out_reg[2].y;
    assign out_ch.out3_z = out_reg[2].z;

endmodule

// ----- hdl/tvdl_checker.sv -----
module tvdl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_opcode,
    input logic       out_valid,
    input logic       out_ready
);

    // a query holds off further transactions while the table is scanned
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_opcode == tvdl_pkg::OP_QUERY) |=> !in_ready)
        else $error("input taken right after a query");

    // clear, append and unused-opcode transactions leave the block ready
    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_opcode != tvdl_pkg::OP_QUERY) |=> in_ready)
        else $error("input stalled after a non-query transaction");

    // a new result only appears at the end of a query
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a scan");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before it was taken");

endmodule

bind triangle_vertex_depth_lookup_top tvdl_checker u_tvdl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);

// ----- verif/tb_triangle_vertex_depth_lookup_top.sv -----
import tvdl_pkg::*;

typedef struct packed {
    logic [1:0]             op;
    point_t                 load;
    vert_t [LANES-1:0]      vert;
} tri_item_t;

typedef point_t [LANES-1:0] tri_pts_t;

class depth_scoreboard #(int DEPTH = 1024);
    point_t           tab [DEPTH];
    int               count;
    int               max_count;
    logic [TOL_W-1:0] tolerance;
    tri_pts_t         expected_q [$];
    int               n_clear;
    int               n_append;
    int               n_query;
    int               n_ignored;
    int               n_checked;
    int               mismatches;

    function new();
        count      = 0;
        max_count  = 0;
        tolerance  = TOL_RESET;
        n_clear    = 0;
        n_append   = 0;
        n_query    = 0;
        n_ignored  = 0;
        n_checked  = 0;
        mismatches = 0;
    endfunction

    function void set_tolerance(logic [TOL_W-1:0] value);
        tolerance = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // first stored point inside the window wins; a hit at the origin counts as a miss
    function point_t resolve_vertex(vert_t v);
        point_t hit;
        int     tol;
        tol = int'(tolerance);
        hit = '0;
        for (int i = 0; i < count; i++)
        begin
            if (int'(v.x) >= int'(tab[i].x) - tol && int'(v.x) <= int'(tab[i].x) + tol &&
                int'(v.y) >= int'(tab[i].y) - tol && int'(v.y) <= int'(tab[i].y) + tol)
            begin
                hit = tab[i];
                break;
            end
        end
        if (hit.x == '0 && hit.y == '0)
        begin
            hit.x = v.x;
            hit.y = v.y;
            hit.z = '0;
        end
        return hit;
    endfunction

    function void note_item(tri_item_t it);
        tri_pts_t res;
        case (it.op)
            OP_CLEAR:
            begin
                count = 0;
                n_clear++;
            end
            OP_APPEND:
            begin
                if (count < DEPTH)
                begin
                    tab[count] = it.load;
                    count++;
                end
                if (count > max_count)
                    max_count = count;
                n_append++;
            end
            OP_QUERY:
            begin
                for (int l = 0; l < LANES; l++)
                    res[l] = resolve_vertex(it.vert[l]);
                expected_q.insert(expected_q.size(), res);
                n_query++;
            end
            default:
                n_ignored++;
        endcase
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function void compare_coord(int lane, string axis, coord_t want, coord_t got);
        if (want !== got)
            report($sformatf("result %0d vertex %0d %s: expected %0d, got %0d",
                             n_checked, lane + 1, axis, want, got));
    endfunction

    function void check_result(tri_pts_t got);
        tri_pts_t want;
        n_checked++;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result %0d with no query waiting: %h", n_checked, got));
            return;
        end
        want = expected_q.pop_front();
        for (int l = 0; l < LANES; l++)
        begin
            compare_coord(l, "x", want[l].x, got[l].x);
            compare_coord(l, "y", want[l].y, got[l].y);
            compare_coord(l, "z", want[l].z, got[l].z);
        end
    endfunction
endclass

module tb_triangle_vertex_depth_lookup_top;

    localparam int         MAX_POINTS  = 1024;
    localparam int         FILL_POINTS = 150;
    localparam int         COORD_MAX   = 524287;
    localparam int         COORD_MIN   = -524288;
    localparam int         LONG_STALL  = 300;
    localparam int         SETTLE      = 8;
    localparam int         STUCK_LIMIT = 8000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [TOL_W-1:0] cfg_wdata;

    tvdl_in_if  in_ch();
    tvdl_out_if out_ch();

    depth_scoreboard #(MAX_POINTS) sb;

    bit sender_burst;
    bit long_stall_req;
    bit long_stall_done;
    int stuck_cycles;
    int mid_tolerance;

    triangle_vertex_depth_lookup_top #(
        .MAX_POINTS (MAX_POINTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:          return coord_t'(COORD_MAX);
            1:          return coord_t'(COORD_MIN);
            2:          return '0;
            3, 4, 5, 6: return coord_t'(int'($urandom_range(0, 256)) - 128);
            default:    return coord_t'($urandom);
        endcase
    endfunction

    // lands inside, on the edge of, or just outside the match window
    function automatic coord_t near_coord(coord_t c, int tol);
        int off;
        case ($urandom_range(0, 3))
            0:       off = tol;
            1:       off = -tol;
            2:       off = int'($urandom_range(0, 2 * tol)) - tol;
            default: off = ($urandom_range(0, 1) == 1) ? tol + 1 : -tol - 1;
        endcase
        return coord_t'(int'(c) + off);
    endfunction

    function automatic tri_item_t noise_item(logic [1:0] op);
        tri_item_t it;
        it.op     = op;
        it.load.x = coord_t'($urandom);
        it.load.y = coord_t'($urandom);
        it.load.z = coord_t'($urandom);
        for (int l = 0; l < LANES; l++)
        begin
            it.vert[l].x = coord_t'($urandom);
            it.vert[l].y = coord_t'($urandom);
        end
        return it;
    endfunction

    function automatic vert_t vtx(int x, int y);
        vert_t v;
        v.x = coord_t'(x);
        v.y = coord_t'(y);
        return v;
    endfunction

    function automatic tri_item_t point_item(int x, int y, int z);
        tri_item_t it;
        it        = noise_item(OP_APPEND);
        it.load.x = coord_t'(x);
        it.load.y = coord_t'(y);
        it.load.z = coord_t'(z);
        return it;
    endfunction

    function automatic tri_item_t query_item(vert_t a, vert_t b, vert_t c);
        tri_item_t it;
        it         = noise_item(OP_QUERY);
        it.vert[0] = a;
        it.vert[1] = b;
        it.vert[2] = c;
        return it;
    endfunction

    function automatic tri_item_t make_append();
        tri_item_t it;
        it        = noise_item(OP_APPEND);
        it.load.x = rand_coord();
        it.load.y = rand_coord();
        it.load.z = rand_coord();
        if ($urandom_range(0, 19) == 0)
        begin
            it.load.x = '0;
            it.load.y = '0;
        end
        return it;
    endfunction

    function automatic tri_item_t make_query();
        tri_item_t it;
        int        pick;
        it = noise_item(OP_QUERY);
        for (int l = 0; l < LANES; l++)
        begin
            if (sb.count > 0 && $urandom_range(0, 9) < 7)
            begin
                pick         = $urandom_range(0, sb.count - 1);
                it.vert[l].x = near_coord(sb.tab[pick].x, int'(sb.tolerance));
                it.vert[l].y = near_coord(sb.tab[pick].y, int'(sb.tolerance));
            end
            else
            begin
                it.vert[l].x = rand_coord();
                it.vert[l].y = rand_coord();
            end
        end
        return it;
    endfunction

    function automatic int real_items();
        return sb.n_clear + sb.n_append + sb.n_query;
    endfunction

    task automatic sender_gap();
        int n;
        n = sender_burst ? 0 : gap_len();
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(input tri_item_t it);
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= it.op;
        in_ch.load_x  <= it.load.x;
        in_ch.load_y  <= it.load.y;
        in_ch.load_z  <= it.load.z;
        in_ch.vert1_x <= it.vert[0].x;
        in_ch.vert1_y <= it.vert[0].y;
        in_ch.vert2_x <= it.vert[1].x;
        in_ch.vert2_y <= it.vert[1].y;
        in_ch.vert3_x <= it.vert[2].x;
        in_ch.vert3_y <= it.vert[2].y;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_item(it);
        sender_gap();
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_tolerance(value);
        cfg_we    <= 1'b0;
    endtask

    task automatic well_formed_run();
        if (sb.count > 48 || $urandom_range(0, 2) == 0)
            send_item(noise_item(OP_CLEAR));
        repeat ($urandom_range(1, 16))
            send_item(make_append());
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(make_append());
            send_item(make_query());
        end
    endtask

    task automatic broken_run();
        send_item(noise_item(OP_CLEAR));
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 2))
                send_item(make_query());
        else
            repeat ($urandom_range(1, 5))
                send_item(make_append());
    endtask

    task automatic random_phase(input int n_items);
        int first;
        int r;
        first = real_items();
        while (real_items() - first < n_items)
        begin
            sender_burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                well_formed_run();
            else if (r < 85)
                repeat ($urandom_range(1, 3))
                    send_item(noise_item(2'($urandom)));
            else
                broken_run();
        end
        sender_burst = 0;
    endtask

    task automatic directed_run();
        send_item(query_item(vtx(COORD_MAX, COORD_MAX), vtx(COORD_MIN, COORD_MIN), vtx(0, 0)));
        send_item(noise_item(OP_UNUSED));
        send_item(point_item(COORD_MAX, COORD_MAX, COORD_MAX));
        send_item(point_item(COORD_MIN, COORD_MIN, COORD_MIN));
        send_item(point_item(0, 0, 77));
        send_item(point_item(160, -160, -5));
        send_item(point_item(170, -150, 9));
        send_item(query_item(vtx(COORD_MAX, COORD_MAX - 16), vtx(COORD_MIN + 16, COORD_MIN),
                             vtx(3, -3)));
        send_item(query_item(vtx(165, -155), vtx(176, -176), vtx(177, -160)));
        send_item(query_item(vtx(COORD_MIN, COORD_MAX), vtx(0, 0), vtx(-17, 17)));
        send_item(noise_item(OP_UNUSED));
        send_item(noise_item(OP_CLEAR));
        send_item(query_item(vtx(160, -160), vtx(0, 0), vtx(COORD_MAX, COORD_MIN)));
    endtask

    // output held off while queries keep coming, so the block backs up
    task automatic pressure_run();
        send_item(noise_item(OP_CLEAR));
        repeat (12)
            send_item(make_append());
        sender_burst   = 1;
        long_stall_req = 1;
        repeat (8)
        begin
            send_item(make_query());
            send_item(make_append());
        end
        sender_burst = 0;
    endtask

    // long table so that the queries before the final clear scan many entries
    task automatic big_table_run();
        send_item(noise_item(OP_CLEAR));
        sender_burst = 1;
        for (int i = 0; i < FILL_POINTS; i++)
        begin
            if (i == FILL_POINTS / 2)
                sender_burst = 0;
            send_item(point_item(int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000, int'($urandom)));
        end
        send_item(point_item(300000, 300000, -77777));
        send_item(point_item(-300000, -300000, 1234));
        send_item(point_item(1, 2, 3));
        send_item(query_item(vtx(300000, 300000), vtx(-300000, -300000), vtx(1, 2)));
        send_item(query_item(vtx(300040, 299960), vtx(300041, 300000), vtx(-2000, 2000)));
        send_item(make_query());
        send_item(noise_item(OP_CLEAR));
        send_item(query_item(vtx(300000, 300000), vtx(0, 0), vtx(1, 2)));
    endtask

    initial
    begin
        int hold_left;
        bit fast;
        hold_left = 0;
        fast      = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_stall_req && !long_stall_done)
            begin
                hold_left       = LONG_STALL;
                long_stall_done = 1;
            end
            else if (hold_left == 0 && !fast && $urandom_range(0, 3) == 0)
                hold_left = gap_len();
            if ($urandom_range(0, 299) == 0)
                fast = !fast;
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tri_pts_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got[0].x = out_ch.out1_x;
            got[0].y = out_ch.out1_y;
            got[0].z = out_ch.out1_z;
            got[1].x = out_ch.out2_x;
            got[1].y = out_ch.out2_y;
            got[1].z = out_ch.out2_z;
            got[2].x = out_ch.out3_x;
            got[2].y = out_ch.out3_y;
            got[2].z = out_ch.out3_z;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         STUCK_LIMIT, sb.pending());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        sb              = new();
        sender_burst    = 0;
        long_stall_req  = 0;
        long_stall_done = 0;
        stuck_cycles    = 0;
        mid_tolerance   = $urandom_range(2, 254);
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.opcode  <= OP_CLEAR;
        in_ch.load_x  <= '0;
        in_ch.load_y  <= '0;
        in_ch.load_z  <= '0;
        in_ch.vert1_x <= '0;
        in_ch.vert1_y <= '0;
        in_ch.vert2_x <= '0;
        in_ch.vert2_y <= '0;
        in_ch.vert3_x <= '0;
        in_ch.vert3_y <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        directed_run();
        drain();
        write_tolerance(8'd0);
        random_phase(40);
        drain();
        write_tolerance(8'd255);
        random_phase(40);
        drain();
        write_tolerance(TOL_W'(mid_tolerance));
        pressure_run();
        random_phase(40);
        drain();
        write_tolerance(8'd1);
        random_phase(40);
        drain();
        write_tolerance(8'd40);
        random_phase(30);
        big_table_run();
        drain();

        $display("covered %0d clears, %0d appends, %0d queries, %0d ignored transactions",
                 sb.n_clear, sb.n_append, sb.n_query, sb.n_ignored);
        $display("%0d results checked, %0d mismatches; match windows 16, 0, 255, %0d, 1 and 40",
                 sb.n_checked, sb.mismatches, mid_tolerance);
        $display("table peak %0d of %0d entries", sb.max_count, MAX_POINTS);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
